[hdl/jsu_pkg.sv]
`default_nettype none

package jsu_pkg;

    // Decoder position inside a quoted string
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PLAIN = 2'd1,
        MODE_ESC   = 2'd2,
        MODE_HEX   = 2'd3
    } t_mode;

    // Result kinds as seen on the output tuser
    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_QUOTE  = 3'd1,
        KIND_BADESC = 3'd2,
        KIND_BADHEX = 3'd3,
        KIND_SURR   = 3'd4,
        KIND_UNTERM = 3'd5
    } t_kind;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_CONT  = 8'h80;

    // Surrogate range 0xD800..0xDFFF shares these top five bits
    localparam logic [4:0] SURR_TOP = 5'b11011;

    // One queued decode: up to three results produced by one input byte
    typedef struct packed {
        logic [1:0] num;    // results in this entry, 1 to 3
        t_kind      kind;   // kind of every result in the entry
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_cmd;

endpackage

`default_nettype wire

[hdl/jsu_front.sv]
`default_nettype none

module jsu_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic         i_start,
    input  wire logic         i_ended,
    input  wire logic [7:0]   i_byte,
    output jsu_pkg::t_cmd     o_cmd,
    output logic              o_push
);

    jsu_pkg::t_mode r_mode, n_mode;
    logic [1:0]     r_cnt, n_cnt;
    logic [11:0]    r_acc, n_acc;

    jsu_pkg::t_mode mode_eff;
    logic [1:0]     cnt_eff;
    logic [11:0]    acc_eff;
    logic           hex_ok;
    logic [3:0]     hex_val;
    logic [15:0]    cp;
    logic           cp_surr;
    logic           esc_ok;
    logic [7:0]     esc_val;

    // A start request restarts decoding before the byte is handled
    assign mode_eff = i_start ? jsu_pkg::MODE_PLAIN : r_mode;
    assign cnt_eff  = i_start ? 2'd0 : r_cnt;
    assign acc_eff  = i_start ? 12'd0 : r_acc;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_val = i_byte[3:0];
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            hex_val = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cp      = {acc_eff, hex_val};
    assign cp_surr = (cp[15:11] == jsu_pkg::SURR_TOP);

    always_comb begin
        esc_ok  = 1'b1;
        esc_val = 8'd0;
        unique case (i_byte)
            jsu_pkg::CH_QUOTE: esc_val = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSL:   esc_val = jsu_pkg::CH_BSL;
            jsu_pkg::CH_SLASH: esc_val = jsu_pkg::CH_SLASH;
            jsu_pkg::CH_B:     esc_val = jsu_pkg::CTL_BS;
            jsu_pkg::CH_F:     esc_val = jsu_pkg::CTL_FF;
            jsu_pkg::CH_N:     esc_val = jsu_pkg::CTL_LF;
            jsu_pkg::CH_R:     esc_val = jsu_pkg::CTL_CR;
            jsu_pkg::CH_T:     esc_val = jsu_pkg::CTL_HT;
            default:           esc_ok  = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        if (i_accept) begin
            n_mode = mode_eff;
            n_cnt  = cnt_eff;
            n_acc  = acc_eff;
            if (mode_eff != jsu_pkg::MODE_IDLE && i_ended) begin
                n_mode = jsu_pkg::MODE_IDLE;
                n_cnt  = 2'd0;
                n_acc  = 12'd0;
            end else begin
                unique case (mode_eff)
                    jsu_pkg::MODE_IDLE: ;
                    jsu_pkg::MODE_PLAIN: begin
                        if (i_byte == jsu_pkg::CH_QUOTE) begin
                            n_mode = jsu_pkg::MODE_IDLE;
                        end else if (i_byte == jsu_pkg::CH_BSL) begin
                            n_mode = jsu_pkg::MODE_ESC;
                        end
                    end
                    jsu_pkg::MODE_ESC: begin
                        if (i_byte == jsu_pkg::CH_U) begin
                            n_mode = jsu_pkg::MODE_HEX;
                            n_cnt  = 2'd0;
                            n_acc  = 12'd0;
                        end else if (esc_ok) begin
                            n_mode = jsu_pkg::MODE_PLAIN;
                        end else begin
                            n_mode = jsu_pkg::MODE_IDLE;
                        end
                    end
                    jsu_pkg::MODE_HEX: begin
                        if (!hex_ok || (cnt_eff == 2'd3 && cp_surr)) begin
                            n_mode = jsu_pkg::MODE_IDLE;
                            n_cnt  = 2'd0;
                            n_acc  = 12'd0;
                        end else if (cnt_eff != 2'd3) begin
                            n_acc = {acc_eff[7:0], hex_val};
                            n_cnt = cnt_eff + 2'd1;
                        end else begin
                            n_mode = jsu_pkg::MODE_PLAIN;
                            n_cnt  = 2'd0;
                            n_acc  = 12'd0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Results for the byte now offered
    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = jsu_pkg::KIND_DATA;
        if (mode_eff != jsu_pkg::MODE_IDLE && i_ended) begin
            o_cmd.num  = 2'd1;
            o_cmd.kind = jsu_pkg::KIND_UNTERM;
        end else begin
            unique case (mode_eff)
                jsu_pkg::MODE_IDLE: ;
                jsu_pkg::MODE_PLAIN: begin
                    if (i_byte == jsu_pkg::CH_QUOTE) begin
                        o_cmd.num  = 2'd1;
                        o_cmd.kind = jsu_pkg::KIND_QUOTE;
                    end else if (i_byte != jsu_pkg::CH_BSL) begin
                        o_cmd.num = 2'd1;
                        o_cmd.b0  = i_byte;
                    end
                end
                jsu_pkg::MODE_ESC: begin
                    if (i_byte != jsu_pkg::CH_U) begin
                        o_cmd.num = 2'd1;
                        if (esc_ok) begin
                            o_cmd.b0 = esc_val;
                        end else begin
                            o_cmd.kind = jsu_pkg::KIND_BADESC;
                        end
                    end
                end
                jsu_pkg::MODE_HEX: begin
                    if (!hex_ok) begin
                        o_cmd.num  = 2'd1;
                        o_cmd.kind = jsu_pkg::KIND_BADHEX;
                    end else if (cnt_eff == 2'd3) begin
                        if (cp_surr) begin
                            o_cmd.num  = 2'd1;
                            o_cmd.kind = jsu_pkg::KIND_SURR;
                        end else if (cp[15:7] == 9'd0) begin
                            o_cmd.num = 2'd1;
                            o_cmd.b0  = cp[7:0];
                        end else if (cp[15:11] == 5'd0) begin
                            o_cmd.num = 2'd2;
                            o_cmd.b0  = jsu_pkg::UTF_LEAD2 | {3'd0, cp[10:6]};
                            o_cmd.b1  = jsu_pkg::UTF_CONT | {2'd0, cp[5:0]};
                        end else begin
                            o_cmd.num = 2'd3;
                            o_cmd.b0  = jsu_pkg::UTF_LEAD3 | {4'd0, cp[15:12]};
                            o_cmd.b1  = jsu_pkg::UTF_CONT | {2'd0, cp[11:6]};
                            o_cmd.b2  = jsu_pkg::UTF_CONT | {2'd0, cp[5:0]};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_push = i_accept && (o_cmd.num != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::MODE_IDLE;
            r_cnt  <= 2'd0;
            r_acc  <= 12'd0;
        end else begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
        end
    end

endmodule

`default_nettype wire

[hdl/jsu_fifo.sv]
`default_nettype none

module jsu_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jsu_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output jsu_pkg::t_cmd      o_head,
    output logic               o_empty,
    output logic               o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_empty = (r_cnt == CW'(0));
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[hdl/jsu_back.sv]
`default_nettype none

module jsu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire jsu_pkg::t_cmd i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [2:0]         o_kind,
    output logic [7:0]         o_byte,
    output logic               o_last
);

    logic       r_valid, n_valid;
    logic [1:0] r_sub, n_sub;
    logic [2:0] r_kind;
    logic [7:0] r_byte;
    logic       r_last;

    logic       load;
    logic       sub_last;
    logic [7:0] sub_byte;

    assign load     = !i_empty && (!r_valid || i_ready);
    assign sub_last = (r_sub == i_head.num - 2'd1);
    assign o_pop    = load && sub_last;

    always_comb begin
        case (r_sub)
            2'd0:    sub_byte = i_head.b0;
            2'd1:    sub_byte = i_head.b1;
            default: sub_byte = i_head.b2;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_sub   = r_sub;
        if (load) begin
            n_valid = 1'b1;
            n_sub   = sub_last ? 2'd0 : r_sub + 2'd1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_head.kind;
            r_byte <= sub_byte;
            r_last <= sub_last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

`default_nettype wire

[hdl/json_string_unescape_decoder.sv]
// JSON string body decoder.
// Input stream: one byte of quoted text per transfer. tuser[0] marks the first
// byte after an opening quote (restarts decoding), tuser[1] marks end of text
// (tdata is ignored then). Bytes seen while idle produce nothing.
// Output stream: one result per transfer. tuser holds the kind (data byte,
// closing quote, bad escape, bad hex, surrogate, unterminated), tdata the
// decoded byte for data results (zero otherwise), tlast flags the final result
// caused by one input byte. A \u escape gives one to three UTF-8 bytes.
// Throughput: one input byte per cycle while the command queue has room; the
// output side emits one result per cycle while the receiver is ready, so a
// \u escape that expands to three bytes occupies the output for three results.
// Path: an accepted input transfer writes a queue entry, and the queue head is
// then loaded into the output register once that register is empty or being
// taken, so each result is presented from the output register.
// Reset (synchronous, active low) empties the queue, drops any result in the
// output register and returns the decoder to idle, outside any string.
// When the receiver stalls, the output register holds its result and the
// queue absorbs up to FIFO_DEPTH result-producing input transfers (one to
// three results each) before input tready drops; bytes that produce nothing
// take no queue slot.
`default_nettype none

module json_string_unescape_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  i_s_axis_tuser,   // [0] start_req, [1] text_ended
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]       o_m_axis_tuser,   // [2:0] kind
    output logic             o_m_axis_tlast    // last result of one input byte
);

    jsu_pkg::t_cmd cmd;
    jsu_pkg::t_cmd head;
    logic          push;
    logic          pop;
    logic          q_empty;
    logic          q_full;
    logic          accept;

    // Take a byte whenever the queue has a free slot
    assign o_s_axis_tready = !q_full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_start  (i_s_axis_tuser[0]),
        .i_ended  (i_s_axis_tuser[1]),
        .i_byte   (i_s_axis_tdata),
        .o_cmd    (cmd),
        .o_push   (push)
    );

    jsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_kind  (o_m_axis_tuser),
        .o_byte  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

[hdl/jsu_checker.sv]
`default_nettype none

module jsu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata,
    input wire logic [2:0] o_m_axis_tuser,
    input wire logic       o_m_axis_tlast
);

    // No result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= 3'(jsu_pkg::KIND_UNTERM))
        else $error("kind out of range");

    // End and error results stand alone and carry no byte
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != 3'(jsu_pkg::KIND_DATA)
        |-> o_m_axis_tlast && o_m_axis_tdata == 8'd0)
        else $error("status result not single or byte not zero");

    // The rest of a multi-byte sequence follows without a gap
    a_seq_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast
        |=> o_m_axis_tvalid && o_m_axis_tuser == 3'(jsu_pkg::KIND_DATA))
        else $error("multi-byte sequence broken");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled output changed");

endmodule

bind json_string_unescape_decoder jsu_checker u_jsu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
